/* sv/periodic_cell_binning_macros.svh */
// Assertion macros for the cell binning RTL
`ifndef PERIODIC_CELL_BINNING_MACROS_SVH
`define PERIODIC_CELL_BINNING_MACROS_SVH

// same-cycle implication
`define PCB_ASSERT_IMP(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("cell binning check failed");

// next-cycle implication
`define PCB_ASSERT_NXT(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("cell binning check failed");

`endif

/* sv/pcb_pkg.sv */
// Types, constants and helpers for the periodic cell binning block
package pcb_pkg;
   localparam int MAX_CELLS_SIDE = 64;
   localparam int CELL_CAPACITY  = 8;
   localparam int NUM_CELLS      = MAX_CELLS_SIDE * MAX_CELLS_SIDE;
   localparam int IDX_W          = 12;
   localparam int OCC_W          = $clog2(CELL_CAPACITY + 1);
   localparam int SLOT_W         = 3;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_FULL    = 2'd1;
   localparam logic [1:0] STATUS_OUTSIDE = 2'd2;

   localparam logic [2:0] CSR_CELLS_ACROSS = 3'd0;
   localparam logic [2:0] CSR_CELLS_DOWN   = 3'd1;
   localparam logic [2:0] CSR_BOX_WIDTH    = 3'd2;
   localparam logic [2:0] CSR_BOX_HEIGHT   = 3'd3;
   localparam logic [2:0] CSR_CELL_WIDTH   = 3'd4;
   localparam logic [2:0] CSR_CELL_HEIGHT  = 3'd5;

   typedef struct packed {
      logic [6:0]  cells_across;
      logic [6:0]  cells_down;
      logic [30:0] box_width;
      logic [30:0] box_height;
      logic [30:0] cell_width;
      logic [30:0] cell_height;
   } cfg_type;

   typedef struct packed {
      logic [IDX_W-1:0]   cell_index;
      logic signed [31:0] offset_x;
      logic signed [31:0] offset_y;
      logic               wrapped_x;
      logic               wrapped_y;
      logic               outside;
   } bin_item_type;

   typedef struct packed {
      logic [IDX_W-1:0]   cell_index;
      logic [SLOT_W-1:0]  slot;
      logic signed [31:0] offset_x;
      logic signed [31:0] offset_y;
      logic               wrapped_x;
      logic               wrapped_y;
      logic [1:0]         status;
   } result_type;

   typedef struct packed {
      logic clearing;
   } back_status_type;

   function automatic logic [6:0] eff_count(logic [6:0] n);
      logic [6:0] r;
      r = n;
      if (n == 7'd0) r = 7'd1;
      else if (n > 7'(MAX_CELLS_SIDE)) r = 7'(MAX_CELLS_SIDE);
      return r;
   endfunction

   function automatic logic [30:0] eff_len(logic [30:0] c);
      return (c == 31'd0) ? 31'd1 : c;
   endfunction
endpackage

/* sv/pcb_front.sv */
// Front end: per-axis cell search by shift-subtract division, offsets, wrap
module pcb_front import pcb_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  logic [31:0]  pos_x,
   input  logic [31:0]  pos_y,
   input  cfg_type      cfg,
   output logic         push_valid,
   input  logic         push_ready,
   output bin_item_type push_item
);
   typedef enum logic [3:0] {
      F_IDLE = 4'b0001,
      F_DIV  = 4'b0010,
      F_FIN  = 4'b0100,
      F_PUSH = 4'b1000
   } front_state_type;

   typedef struct packed {
      logic        ok;
      logic        wrap;
      logic [5:0]  idx;
      logic [31:0] off;
   } axis_res_type;

   function automatic axis_res_type axis_finish(logic signed [35:0] s, logic [34:0] rem,
                                                logic [6:0] q, logic [6:0] n,
                                                logic [30:0] c, logic [30:0] box);
      axis_res_type       r;
      logic signed [37:0] d;
      logic signed [36:0] h;
      r.ok   = !s[35] && ({4'b0, rem} < {7'b0, c, 1'b0}) && (q <= n);
      r.wrap = (q == n);
      if (r.wrap)
         d = $signed({{2{s[35]}}, s}) - $signed({6'b0, box, 1'b0}) - $signed({7'b0, c});
      else
         d = $signed({3'b0, rem}) - $signed({7'b0, c});
      h = d[37:1];
      // saturate the halved offset to 32 bits
      if (!h[36] && (|h[36:31]))
         r.off = 32'h7FFF_FFFF;
      else if (h[36] && !(&h[36:31]))
         r.off = 32'h8000_0000;
      else
         r.off = h[31:0];
      r.idx = r.wrap ? 6'd0 : q[5:0];
      return r;
   endfunction

   front_state_type    state_ff, state_in;
   logic [2:0]         step_ff, step_in;
   logic signed [35:0] sx_ff, sx_in, sy_ff, sy_in;
   logic [34:0]        remx_ff, remx_in, remy_ff, remy_in;
   logic [37:0]        dvx_ff, dvx_in, dvy_ff, dvy_in;
   logic [6:0]         qx_ff, qx_in, qy_ff, qy_in;
   bin_item_type       item_ff, item_in;
   logic [30:0]        cx, cy;
   logic [6:0]         nx, ny;
   logic               gex, gey;
   axis_res_type       rx, ry;
   logic [12:0]        lin;

   assign cx  = eff_len(cfg.cell_width);
   assign cy  = eff_len(cfg.cell_height);
   assign nx  = eff_count(cfg.cells_across);
   assign ny  = eff_count(cfg.cells_down);
   assign gex = ({3'b0, remx_ff} >= dvx_ff);
   assign gey = ({3'b0, remy_ff} >= dvy_ff);
   assign rx  = axis_finish(sx_ff, remx_ff, qx_ff, nx, cx, cfg.box_width);
   assign ry  = axis_finish(sy_ff, remy_ff, qy_ff, ny, cy, cfg.box_height);
   assign lin = 13'(ry.idx * nx) + {7'b0, rx.idx};

   assign in_ready   = (state_ff == F_IDLE);
   assign push_valid = (state_ff == F_PUSH);
   assign push_item  = item_ff;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      sx_in    = sx_ff;
      sy_in    = sy_ff;
      remx_in  = remx_ff;
      remy_in  = remy_ff;
      dvx_in   = dvx_ff;
      dvy_in   = dvy_ff;
      qx_in    = qx_ff;
      qy_in    = qy_ff;
      item_in  = item_ff;
      case (state_ff)
         F_IDLE: begin
            if (in_valid) begin
               sx_in    = ($signed({{4{pos_x[31]}}, pos_x}) <<< 1)
                          + $signed({5'b0, cfg.box_width});
               sy_in    = ($signed({{4{pos_y[31]}}, pos_y}) <<< 1)
                          + $signed({5'b0, cfg.box_height});
               remx_in  = sx_in[34:0];
               remy_in  = sy_in[34:0];
               dvx_in   = {cx, 7'b0};
               dvy_in   = {cy, 7'b0};
               qx_in    = 7'd0;
               qy_in    = 7'd0;
               step_in  = 3'd0;
               state_in = F_DIV;
            end
         end
         F_DIV: begin
            // one quotient bit per cycle on each axis
            if (gex) remx_in = remx_ff - dvx_ff[34:0];
            if (gey) remy_in = remy_ff - dvy_ff[34:0];
            qx_in   = {qx_ff[5:0], gex};
            qy_in   = {qy_ff[5:0], gey};
            dvx_in  = dvx_ff >> 1;
            dvy_in  = dvy_ff >> 1;
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd6) state_in = F_FIN;
         end
         F_FIN: begin
            item_in.outside = !(rx.ok && ry.ok);
            if (rx.ok && ry.ok) begin
               item_in.cell_index = lin[IDX_W-1:0];
               item_in.offset_x   = rx.off;
               item_in.offset_y   = ry.off;
               item_in.wrapped_x  = rx.wrap;
               item_in.wrapped_y  = ry.wrap;
            end else begin
               item_in.cell_index = '0;
               item_in.offset_x   = '0;
               item_in.offset_y   = '0;
               item_in.wrapped_x  = 1'b0;
               item_in.wrapped_y  = 1'b0;
            end
            state_in = F_PUSH;
         end
         F_PUSH: begin
            if (push_ready) state_in = F_IDLE;
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      step_ff <= step_in;
      sx_ff   <= sx_in;
      sy_ff   <= sy_in;
      remx_ff <= remx_in;
      remy_ff <= remy_in;
      dvx_ff  <= dvx_in;
      dvy_ff  <= dvy_in;
      qx_ff   <= qx_in;
      qy_ff   <= qy_in;
      item_ff <= item_in;
   end
endmodule

/* sv/pcb_queue.sv */
// Two-entry queue between the binning front end and the occupancy back end
module pcb_queue import pcb_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push_valid,
   output logic         push_ready,
   input  bin_item_type push_item,
   output logic         pop_valid,
   input  logic         pop_ready,
   output bin_item_type pop_item
);
   bin_item_type slots_ff [2];
   logic         wr_ptr_ff, rd_ptr_ff;
   logic [1:0]   count_ff;
   logic         do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_item   = slots_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) wr_ptr_ff <= !wr_ptr_ff;
         if (do_pop) rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_ff + {1'b0, do_push} - {1'b0, do_pop};
      end
      if (do_push) slots_ff[wr_ptr_ff] <= push_item;
   end
endmodule

/* sv/pcb_back.sv */
// Back end: occupancy memory with clearing pass, slot assignment, result register
`include "periodic_cell_binning_macros.svh"
module pcb_back import pcb_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            pop_valid,
   output logic            pop_ready,
   input  bin_item_type    pop_item,
   output back_status_type status,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output result_type      rsp_item
);
   typedef enum logic [2:0] {
      B_CLEAR = 3'b001,
      B_IDLE  = 3'b010,
      B_READ  = 3'b100
   } back_state_type;

   back_state_type   state_ff, state_in;
   logic [IDX_W-1:0] clr_cnt_ff;
   logic [OCC_W-1:0] occ_mem [NUM_CELLS];
   logic [OCC_W-1:0] rd_ff;
   bin_item_type     item_ff;
   result_type       rsp_ff, rsp_in;
   logic             rsp_valid_ff;
   logic             pop, full, mem_we;
   logic [IDX_W-1:0] mem_waddr;
   logic [OCC_W-1:0] mem_wdata;

   assign pop       = (state_ff == B_IDLE) && pop_valid && (!rsp_valid_ff || rsp_ready);
   assign pop_ready = pop;
   assign full      = (rd_ff >= OCC_W'(CELL_CAPACITY));
   assign mem_we    = (state_ff == B_CLEAR) ||
                      ((state_ff == B_READ) && !item_ff.outside && !full);
   assign mem_waddr = (state_ff == B_CLEAR) ? clr_cnt_ff : item_ff.cell_index;
   assign mem_wdata = (state_ff == B_CLEAR) ? '0 : rd_ff + OCC_W'(1);

   assign status.clearing = (state_ff == B_CLEAR);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_item        = rsp_ff;

   always_comb begin
      state_in = state_ff;
      rsp_in   = rsp_ff;
      case (state_ff)
         B_CLEAR: if (clr_cnt_ff == IDX_W'(NUM_CELLS - 1)) state_in = B_IDLE;
         B_IDLE:  if (pop) state_in = B_READ;
         B_READ: begin
            rsp_in.cell_index = item_ff.cell_index;
            rsp_in.offset_x   = item_ff.offset_x;
            rsp_in.offset_y   = item_ff.offset_y;
            rsp_in.wrapped_x  = item_ff.wrapped_x;
            rsp_in.wrapped_y  = item_ff.wrapped_y;
            if (item_ff.outside) begin
               rsp_in.slot   = '0;
               rsp_in.status = STATUS_OUTSIDE;
            end else if (full) begin
               rsp_in.slot   = '0;
               rsp_in.status = STATUS_FULL;
            end else begin
               rsp_in.slot   = rd_ff[SLOT_W-1:0];
               rsp_in.status = STATUS_OK;
            end
            state_in = B_IDLE;
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == B_CLEAR) clr_cnt_ff <= clr_cnt_ff + IDX_W'(1);
         if (state_ff == B_READ) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
      rsp_ff <= rsp_in;
      if (pop) item_ff <= pop_item;
   end

   // occupancy store: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) occ_mem[mem_waddr] <= mem_wdata;
      rd_ff <= occ_mem[pop_item.cell_index];
   end

   `PCB_ASSERT_IMP(a_clear_quiet, clock, reset, state_ff == B_CLEAR, !rsp_valid_ff && !pop)
   `PCB_ASSERT_IMP(a_outside_zero, clock, reset,
                   rsp_valid_ff && rsp_ff.status == STATUS_OUTSIDE,
                   rsp_ff.cell_index == '0 && rsp_ff.slot == '0)
   `PCB_ASSERT_NXT(a_pop_reads, clock, reset, pop, state_ff == B_READ)
endmodule

/* sv/periodic_cell_binning.sv */
// Top level: configuration registers, front end, queue and occupancy back end
//
//   channel  direction  transfer when             payload
//   req      in         req_tvalid & req_tready   pos_x, pos_y
//   rsp      out        rsp_tvalid & rsp_tready   cell index, slot, offsets, wraps, status
//   csr      in         csr_we                    register index and value
//
// The front end divides for each item's cell, one quotient bit per cycle on each axis,
// then forms offsets and wraps; the back end reads the occupancy, then updates it and
// registers the result. After reset the occupancy store's 4096 cells are cleared,
// one cell a cycle, with req_tready low. A stalled result holds the back end; the
// queue holds two items, so the front end can finish up to three more before it stalls.
module periodic_cell_binning import pcb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // pos_x[31:0], pos_y[63:32]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata,   // cell_index[11:0], slot[14:12], offset_x[46:15],
                                    // offset_y[78:47], wrapped_x[79], wrapped_y[80],
                                    // status[82:81], zero fill
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [30:0] csr_wdata
);
   cfg_type         cfg_ff;
   logic            front_ready, push_valid, push_ready, pop_valid, pop_ready;
   bin_item_type    push_item, pop_item;
   back_status_type back_status;
   result_type      rsp_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cells_across <= 7'd64;
         cfg_ff.cells_down   <= 7'd64;
         cfg_ff.box_width    <= 31'd4194304;
         cfg_ff.box_height   <= 31'd4194304;
         cfg_ff.cell_width   <= 31'd65536;
         cfg_ff.cell_height  <= 31'd65536;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CELLS_ACROSS: cfg_ff.cells_across <= csr_wdata[6:0];
            CSR_CELLS_DOWN:   cfg_ff.cells_down   <= csr_wdata[6:0];
            CSR_BOX_WIDTH:    cfg_ff.box_width    <= csr_wdata;
            CSR_BOX_HEIGHT:   cfg_ff.box_height   <= csr_wdata;
            CSR_CELL_WIDTH:   cfg_ff.cell_width   <= csr_wdata;
            CSR_CELL_HEIGHT:  cfg_ff.cell_height  <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_tready = front_ready && !back_status.clearing;

   pcb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid && !back_status.clearing),
      .in_ready   (front_ready),
      .pos_x      (req_tdata[31:0]),
      .pos_y      (req_tdata[63:32]),
      .cfg        (cfg_ff),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   pcb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   pcb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_item  (pop_item),
      .status    (back_status),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_item  (rsp_item)
   );

   assign rsp_tdata = {5'b0, rsp_item.status, rsp_item.wrapped_y, rsp_item.wrapped_x,
                       rsp_item.offset_y, rsp_item.offset_x, rsp_item.slot,
                       rsp_item.cell_index};
endmodule
